>>> hdl/fhs_pkg.sv
// Shared types and constants for the frame header stripper.
// Used by every module in hdl/; depends on nothing.
`default_nettype none

package fhs_pkg;

   localparam int MAX_FRAME_BYTES = 65535;
   localparam int POS_W           = 16;
   localparam int LEN_W           = 6;
   localparam int HDR_BYTES_W     = 6;

   // Result queue between parser and output side (power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_WIRELESS_MODE = 1'b0;
   localparam logic REG_HDR_BYTES     = 1'b1;
   localparam logic [HDR_BYTES_W-1:0] HDR_BYTES_RESET = 6'd24;

   // Parse phases
   localparam logic [3:0] PH_LINK    = 4'd0;
   localparam logic [3:0] PH_ETH     = 4'd1;
   localparam logic [3:0] PH_WLAN    = 4'd2;
   localparam logic [3:0] PH_SNAP    = 4'd3;
   localparam logic [3:0] PH_IP      = 4'd4;
   localparam logic [3:0] PH_TCP     = 4'd5;
   localparam logic [3:0] PH_UDP     = 4'd6;
   localparam logic [3:0] PH_PAYLOAD = 4'd7;
   localparam logic [3:0] PH_DROP    = 4'd8;

   // Frame status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_TRUNCATED   = 4'd1;
   localparam logic [3:0] ST_NOT_DATA    = 4'd2;
   localparam logic [3:0] ST_NO_SNAP     = 4'd3;
   localparam logic [3:0] ST_BAD_OUI     = 4'd4;
   localparam logic [3:0] ST_BAD_TYPE    = 4'd5;
   localparam logic [3:0] ST_BAD_IHL     = 4'd6;
   localparam logic [3:0] ST_BAD_PROTO   = 4'd7;
   localparam logic [3:0] ST_BAD_TCP_OFF = 4'd8;
   localparam logic [3:0] ST_BAD_UDP_LEN = 4'd9;

   // Header field values
   localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
   localparam logic [15:0] ETYPE_VLAN   = 16'h8100;
   localparam logic [7:0]  LLC_SNAP_SAP = 8'hAA;
   localparam logic [7:0]  PROTO_TCP    = 8'h06;
   localparam logic [7:0]  PROTO_UDP    = 8'h11;
   localparam logic [LEN_W-1:0] MIN_HDR_LEN = 6'd20;
   localparam logic [15:0] MIN_UDP_LEN  = 16'd8;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_payload;
      logic       end_of_frame;
      logic [3:0] frame_status;
   } rsp_type;

   typedef struct packed {
      logic                   wireless_mode;
      logic [HDR_BYTES_W-1:0] wireless_header_bytes;
   } cfg_type;

endpackage

`default_nettype wire

>>> hdl/fhs_regs.sv
// Configuration registers behind the APB-style port.
// Depends on fhs_pkg.
`default_nettype none

module fhs_regs
   import fhs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    reg_sel;
   logic    wr_en;

   assign reg_sel    = csr_paddr[CSR_ADDR_W-1];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_WIRELESS_MODE: cfg_in.wireless_mode = csr_pwdata[0];
            REG_HDR_BYTES:     cfg_in.wireless_header_bytes = csr_pwdata[HDR_BYTES_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_WIRELESS_MODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.wireless_mode};
         REG_HDR_BYTES:     csr_prdata = {{(CSR_DATA_W-HDR_BYTES_W){1'b0}},
                                          cfg_ff.wireless_header_bytes};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wireless_mode         <= 1'b0;
         cfg_ff.wireless_header_bytes <= HDR_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/fhs_parser.sv
// Front side: takes frame bytes, walks the link, IPv4 and transport headers,
// and pushes payload bytes and end-of-frame status into the result queue.
// Depends on fhs_pkg.
`default_nettype none

module fhs_parser
   import fhs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    push_ready,
   output logic         push_valid,
   output rsp_type      push_data
);

   logic [3:0]       phase_ff, phase_in, phase_cur;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [15:0]      saved_ff, saved_in;
   logic [7:0]       proto_ff, proto_in;
   logic [23:0]      oui_ff, oui_in;
   logic [3:0]       err_ff, err_in;

   logic             accept;
   logic             emit;
   logic [POS_W-1:0] offset;
   logic [POS_W-1:0] hdr_len;
   logic [15:0]      type_word;
   logic [LEN_W-1:0] len_v;
   logic [7:0]       proto_v;
   logic [23:0]      oui_v;
   logic             bad;
   logic [3:0]       status;
   logic [7:0]       b;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.frame_byte;

   always_comb begin
      phase_cur = (phase_ff == PH_LINK) ? (cfg.wireless_mode ? PH_WLAN : PH_ETH) : phase_ff;
      offset    = pos_ff - start_ff;
      hdr_len   = {{(POS_W-HDR_BYTES_W){1'b0}}, cfg.wireless_header_bytes};
      type_word = saved_ff | {8'h00, b};
      emit      = (phase_cur == PH_PAYLOAD);
      len_v     = len_ff;
      proto_v   = proto_ff;
      oui_v     = oui_ff;
      bad       = 1'b0;

      phase_in = phase_cur;
      start_in = start_ff;
      len_in   = len_ff;
      saved_in = saved_ff;
      proto_in = proto_ff;
      oui_in   = oui_ff;
      err_in   = err_ff;
      status   = ST_OK;

      if (phase_cur != PH_PAYLOAD && phase_cur != PH_DROP) begin
         if (pos_ff >= POS_W'(MAX_FRAME_BYTES)) begin
            err_in   = ST_TRUNCATED;
            phase_in = PH_DROP;
         end else begin
            unique case (phase_cur)
               PH_ETH: begin
                  if (offset == 16'd12 || offset == 16'd16) begin
                     saved_in = {b, 8'h00};
                  end else if (offset == 16'd13) begin
                     saved_in = type_word;
                     if (type_word == ETYPE_IPV4) begin
                        phase_in = PH_IP;
                        start_in = pos_ff + 16'd1;
                        len_in   = '0;
                     end else if (type_word != ETYPE_VLAN) begin
                        err_in   = ST_BAD_TYPE;
                        phase_in = PH_DROP;
                     end
                  end else if (offset == 16'd17) begin
                     saved_in = type_word;
                     if (type_word == ETYPE_IPV4) begin
                        phase_in = PH_IP;
                        start_in = pos_ff + 16'd1;
                        len_in   = '0;
                     end else begin
                        err_in   = ST_BAD_TYPE;
                        phase_in = PH_DROP;
                     end
                  end
               end
               PH_WLAN: begin
                  if (pos_ff == '0 && b[3:2] != 2'd2) begin
                     err_in   = ST_NOT_DATA;
                     phase_in = PH_DROP;
                  end else if (pos_ff == hdr_len && b != LLC_SNAP_SAP) begin
                     err_in   = ST_NO_SNAP;
                     phase_in = PH_DROP;
                  end else if (pos_ff == hdr_len + 16'd2) begin
                     // LLC control is one byte for U-format, two otherwise
                     phase_in = PH_SNAP;
                     start_in = (b[1:0] == 2'b11) ? hdr_len + 16'd3 : hdr_len + 16'd4;
                     len_in   = '0;
                  end
               end
               PH_SNAP: begin
                  if (pos_ff >= start_ff) begin
                     if (offset <= 16'd2) begin
                        oui_v  = (offset == '0) ? {16'h0000, b} : {oui_ff[15:0], b};
                        oui_in = oui_v;
                        if (offset == 16'd2 && oui_v != '0) begin
                           err_in   = ST_BAD_OUI;
                           phase_in = PH_DROP;
                        end
                     end else if (offset == 16'd3) begin
                        saved_in = {b, 8'h00};
                     end else if (offset == 16'd4) begin
                        saved_in = type_word;
                        if (type_word == ETYPE_IPV4) begin
                           phase_in = PH_IP;
                           start_in = pos_ff + 16'd1;
                           len_in   = '0;
                        end else begin
                           err_in   = ST_BAD_TYPE;
                           phase_in = PH_DROP;
                        end
                     end
                  end
               end
               PH_IP: begin
                  if (offset == '0) begin
                     len_v  = {b[3:0], 2'b00};
                     len_in = len_v;
                     if (len_v < MIN_HDR_LEN) begin
                        bad      = 1'b1;
                        err_in   = ST_BAD_IHL;
                        phase_in = PH_DROP;
                     end
                  end else if (offset == 16'd9) begin
                     proto_v  = b;
                     proto_in = b;
                     if (b != PROTO_TCP && b != PROTO_UDP) begin
                        bad      = 1'b1;
                        err_in   = ST_BAD_PROTO;
                        phase_in = PH_DROP;
                     end
                  end
                  if (!bad && len_v >= MIN_HDR_LEN &&
                      offset == {{(POS_W-LEN_W){1'b0}}, len_v} - 16'd1) begin
                     phase_in = (proto_v == PROTO_TCP) ? PH_TCP : PH_UDP;
                     start_in = pos_ff + 16'd1;
                     len_in   = '0;
                  end
               end
               PH_TCP: begin
                  if (offset == 16'd12) begin
                     len_v  = {b[7:4], 2'b00};
                     len_in = len_v;
                     if (len_v < MIN_HDR_LEN) begin
                        bad      = 1'b1;
                        err_in   = ST_BAD_TCP_OFF;
                        phase_in = PH_DROP;
                     end
                  end
                  if (!bad && len_v >= MIN_HDR_LEN &&
                      offset == {{(POS_W-LEN_W){1'b0}}, len_v} - 16'd1) begin
                     phase_in = PH_PAYLOAD;
                     start_in = pos_ff + 16'd1;
                     len_in   = '0;
                  end
               end
               PH_UDP: begin
                  if (offset == 16'd4) begin
                     saved_in = {b, 8'h00};
                  end else if (offset == 16'd5) begin
                     saved_in = type_word;
                     if (type_word < MIN_UDP_LEN) begin
                        err_in   = ST_BAD_UDP_LEN;
                        phase_in = PH_DROP;
                     end
                  end else if (offset == 16'd7) begin
                     phase_in = PH_PAYLOAD;
                     start_in = pos_ff + 16'd1;
                     len_in   = '0;
                  end
               end
               default: phase_in = phase_cur;
            endcase
         end
      end

      // Saturate so a long payload never wraps back into header offsets
      pos_in = (pos_ff != '1) ? pos_ff + 16'd1 : pos_ff;

      if (req_data.frame_end) begin
         if (phase_in == PH_DROP) status = err_in;
         else                     status = emit ? ST_OK : ST_TRUNCATED;
         pos_in   = '0;
         phase_in = PH_LINK;
         start_in = '0;
         len_in   = '0;
         err_in   = ST_OK;
      end
   end

   assign push_valid             = accept && (emit || req_data.frame_end);
   assign push_data.payload_byte = emit ? b : 8'h00;
   assign push_data.has_payload  = emit;
   assign push_data.end_of_frame = req_data.frame_end;
   assign push_data.frame_status = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINK;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         saved_ff <= '0;
         proto_ff <= '0;
         oui_ff   <= '0;
         err_ff   <= ST_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         saved_ff <= saved_in;
         proto_ff <= proto_in;
         oui_ff   <= oui_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/fhs_queue.sv
// Back side: small register queue of results that drives the rsp channel.
// Depends on fhs_pkg.
`default_nettype none

module fhs_queue
   import fhs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire rsp_type push_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   rsp_type                slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/frame_header_stripper.sv
// Frame header stripper: one frame byte per cycle in, payload bytes and
// end-of-frame status out. Each result is registered in the result queue
// and shows on rsp from there. Throughput: one byte per cycle; the parser
// stalls only when its 4-entry result queue is full.
// Reset (synchronous, active high): parser back to the link header, queue
// empty, wireless_mode 0, wireless_header_bytes 24.
`default_nettype none

module frame_header_stripper
   import fhs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;
   logic    push_valid;
   logic    push_ready;
   rsp_type push_data;

   fhs_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fhs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   fhs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Every transaction carries a payload byte or closes a frame
   a_no_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.has_payload || rsp_data.end_of_frame))
      else $error("result with neither payload nor end of frame");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.end_of_frame) |-> (rsp_data.frame_status == ST_OK))
      else $error("status reported before end of frame");

   a_ok_means_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.end_of_frame && rsp_data.frame_status == ST_OK)
         |-> rsp_data.has_payload)
      else $error("ok status on a final byte that is not payload");

   // The front stalls only when results are backed up
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty result queue");

endmodule

`default_nettype wire
